// ===== design/tgcr_pkg.sv =====
// tgcr_pkg: shared types, codes and pixel helpers of the cell row renderer
// no dependencies; imported by the renderer, its font ram user and the checker
package tgcr_pkg;

    // default glyph count of the font store (8 lines of 8 bits per glyph)
    localparam int GLYPH_COUNT_DEF = 128;
    localparam int GLYPH_LINES     = 8;

    // drawn area limits and text column limit
    localparam logic [4:0] COL_FIRST  = 5'd2;
    localparam logic [4:0] COL_END    = 5'd29;
    localparam logic [4:0] TEXT_COL_END = 5'd26;

    // display_mode bits
    localparam int MODE_INV_X_BIT = 6;
    localparam int MODE_INV_Y_BIT = 7;

    // input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // graphics modes
    typedef enum logic [1:0] {
        GMODE_NONE0  = 2'd0,
        GMODE_BLOCK  = 2'd1,
        GMODE_NONE2  = 2'd2,
        GMODE_HALVES = 2'd3
    } t_gmode;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_DISPLAY_MODE  = 2'd0,
        REG_SCREEN_COLORS = 2'd1,
        REG_TEXT_WINDOW   = 2'd2,
        REG_TEXT_COLORS   = 2'd3
    } t_reg_idx;

    // kind of the rendered cell
    typedef enum logic [1:0] {
        KIND_BG     = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_BLOCK  = 2'd2,
        KIND_HALVES = 2'd3
    } t_cell_kind;

    // item held between font read and output register
    typedef struct packed {
        t_cell_kind  kind;
        logic        use_font;
        logic [3:0]  fg;
        logic [3:0]  bg;
        logic [31:0] pixels;
    } t_row_stage;

    // one colour on all eight pixels
    function automatic logic [31:0] fill_row(input logic [3:0] colour);
        fill_row = {8{colour}};
    endfunction

    // font byte to pixels, bit 7 leftmost
    function automatic logic [31:0] pattern_row(input logic [7:0] pat,
                                                input logic [3:0] on_c,
                                                input logic [3:0] off_c);
        logic [31:0] row;
        row = '0;
        for (int i = 0; i < 8; i++) begin
            row[4*i +: 4] = pat[i] ? on_c : off_c;
        end
        pattern_row = row;
    endfunction

endpackage

// ===== design/tgcr_ram.sv =====
// tgcr_ram: generic single write port, single read port ram with registered read
// no dependencies
module tgcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/text_graphics_cell_row_renderer.sv =====
// text_graphics_cell_row_renderer: background layer cell row renderer
// depends on tgcr_pkg and tgcr_ram (font store)
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_ready     i_cmd, cell and font fields
//   out      output     o_out_valid / i_out_ready   o_pixels, o_cell_kind
//   cfg      input      psel/penable/pwrite, pready paddr, pwdata, prdata
//
// one item per cycle while the output is not stalled; a render item goes
// from the render stage (font ram read at the accepting edge) to the output
// register (pixel build) when that register frees up; a load writes the font
// store and gives no item. synchronous active low reset clears valid state and
// the configuration registers; the font store is not cleared. a stalled output
// holds the render stage, which holds the ram read data until the item moves on.
module text_graphics_cell_row_renderer
    import tgcr_pkg::*;
#(
    parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [4:0]  i_cell_col,
    input  logic [3:0]  i_cell_row,
    input  logic [3:0]  i_line,
    input  logic [7:0]  i_cell_byte,
    input  logic [6:0]  i_glyph_code,
    input  logic [2:0]  i_glyph_line,
    input  logic [7:0]  i_glyph_bits,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pixels,
    output logic [1:0]  o_cell_kind,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_LINES;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);

    logic [7:0] r_display_mode, r_screen_colors, r_text_window, r_text_colors;
    t_reg_idx   cfg_idx;
    logic       cfg_wr;

    logic       s1_advance, in_accept, render_acc, load_acc;
    logic       r_s1_valid, r_out_valid;
    t_row_stage r_s1, n_s1;
    logic [31:0] r_out_pixels, n_out_pixels;
    t_cell_kind r_out_kind;

    logic [FONT_AW-1:0] font_waddr, font_raddr;
    logic [7:0]         font_rdata;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_mode  <= '0;
            r_screen_colors <= '0;
            r_text_window   <= '0;
            r_text_colors   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DISPLAY_MODE:  r_display_mode  <= pwdata[7:0];
                REG_SCREEN_COLORS: r_screen_colors <= pwdata[7:0];
                REG_TEXT_WINDOW:   r_text_window   <= pwdata[7:0];
                REG_TEXT_COLORS:   r_text_colors   <= pwdata[7:0];
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_DISPLAY_MODE:  prdata = {24'd0, r_display_mode};
            REG_SCREEN_COLORS: prdata = {24'd0, r_screen_colors};
            REG_TEXT_WINDOW:   prdata = {24'd0, r_text_window};
            REG_TEXT_COLORS:   prdata = {24'd0, r_text_colors};
        endcase
    end

    // handshake: the render stage moves when the output register frees up
    assign s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;
    assign render_acc = in_accept && (i_cmd == CMD_RENDER);
    assign load_acc   = in_accept && (i_cmd == CMD_LOAD);

    // cell classification and font address
    logic       drawn, in_x, in_y, is_text, blk_left, blk_right;
    logic [4:0] xmax;
    logic [3:0] ymax, back, gcol, half_c;
    logic [6:0] code;
    t_gmode     gmode;

    always_comb begin
        back  = r_screen_colors[3:0];
        gcol  = r_screen_colors[7:4];
        gmode = t_gmode'(r_display_mode[1:0]);
        drawn = (i_cell_row != 4'd0) && (i_cell_col >= COL_FIRST)
                && (i_cell_col < COL_END);
        xmax  = {r_text_window[3:0], 1'b0};
        ymax  = r_text_window[7:4];
        in_x  = r_display_mode[MODE_INV_X_BIT] ? (i_cell_col >= xmax) : (i_cell_col < xmax);
        in_y  = r_display_mode[MODE_INV_Y_BIT] ? (i_cell_row >= ymax) : (i_cell_row < ymax);
        is_text = in_x && in_y;
        code  = (i_cell_col < TEXT_COL_END) ? i_cell_byte[6:0] : 7'd0;
        blk_left  = i_cell_byte[{~i_line[3:2], 1'b1}];
        blk_right = i_cell_byte[{~i_line[3:2], 1'b0}];
        half_c    = i_line[3] ? i_cell_byte[3:0] : i_cell_byte[7:4];

        n_s1.kind     = KIND_BG;
        n_s1.use_font = 1'b0;
        n_s1.fg       = r_text_colors[7:4];
        n_s1.bg       = r_text_colors[3:0];
        n_s1.pixels   = fill_row(back);
        if (drawn) begin
            priority if (is_text) begin
                n_s1.kind     = KIND_TEXT;
                n_s1.use_font = (code != 7'd0) && !i_line[3];
                n_s1.pixels   = fill_row(r_text_colors[3:0]);
            end else if (gmode == GMODE_BLOCK) begin
                n_s1.kind   = KIND_BLOCK;
                n_s1.pixels = {{4{blk_left ? gcol : back}}, {4{blk_right ? gcol : back}}};
            end else if (gmode == GMODE_HALVES) begin
                n_s1.kind   = KIND_HALVES;
                n_s1.pixels = fill_row((half_c != 4'd0) ? half_c : back);
            end else begin
                n_s1.kind = KIND_BG;
            end
        end
    end

    assign font_raddr = FONT_AW'({code, i_line[2:0]});
    assign font_waddr = FONT_AW'({i_glyph_code, i_glyph_line});

    // font store
    tgcr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (load_acc),
        .i_waddr (font_waddr),
        .i_wdata (i_glyph_bits),
        .i_re    (render_acc),
        .i_raddr (font_raddr),
        .o_rdata (font_rdata)
    );

    // render stage, waits for the ram read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= render_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (render_acc) begin
            r_s1 <= n_s1;
        end
    end

    // pixel build from the font byte
    assign n_out_pixels = r_s1.use_font ? pattern_row(font_rdata, r_s1.fg, r_s1.bg)
                                        : r_s1.pixels;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_out_pixels <= n_out_pixels;
            r_out_kind   <= r_s1.kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixels    = r_out_pixels;
    assign o_cell_kind = r_out_kind;

endmodule

// ===== design/tgcr_checker.sv =====
// tgcr_checker: port level assertions of the cell row renderer, with bind
// depends on tgcr_pkg; bound to text_graphics_cell_row_renderer
module tgcr_checker
    import tgcr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pixels,
    input logic [1:0]  o_cell_kind,
    input logic        pready
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixels)
        && $stable(o_cell_kind))
        else $error("output item changed while stalled");

    // no item straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // the configuration port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

    // background and colour half cells are one colour across the row
    a_uniform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_cell_kind == KIND_BG || o_cell_kind == KIND_HALVES)
        |-> o_pixels == {8{o_pixels[31:28]}})
        else $error("uniform cell with mixed pixels");

    // block graphics: each half of the row is one colour
    a_block_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cell_kind == KIND_BLOCK
        |-> o_pixels[31:16] == {4{o_pixels[31:28]}}
        && o_pixels[15:0] == {4{o_pixels[15:12]}})
        else $error("block cell with mixed half");

endmodule

bind text_graphics_cell_row_renderer tgcr_checker u_tgcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pixels    (o_pixels),
    .o_cell_kind (o_cell_kind),
    .pready      (pready)
);

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for the background layer cell row renderer
// depends on tgcr_pkg and the renderer rtl; drives font loads, renders and register writes
// and checks every output row against an in-bench prediction or a value from the directed table
module tb_top;
    import tgcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 4;

    // one input item as seen on the input channel
    typedef struct packed {
        logic       cmd;
        logic [4:0] cell_col;
        logic [3:0] cell_row;
        logic [3:0] line;
        logic [7:0] cell_byte;
        logic [6:0] glyph_code;
        logic [2:0] glyph_line;
        logic [7:0] glyph_bits;
    } t_cell_item;

    // one rendered row
    typedef struct packed {
        logic [31:0] pixels;
        t_cell_kind  kind;
    } t_row_res;

    typedef enum logic {
        STEP_REG  = 1'b0,
        STEP_ITEM = 1'b1
    } t_step_kind;

    // one row of the directed table
    typedef struct packed {
        t_step_kind step;
        t_reg_idx   reg_idx;
        logic [7:0] reg_val;
        t_cell_item item;
        logic       typed;
        t_row_res   row;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = CMD_LOAD;
    logic [4:0]  i_cell_col = '0;
    logic [3:0]  i_cell_row = '0;
    logic [3:0]  i_line = '0;
    logic [7:0]  i_cell_byte = '0;
    logic [6:0]  i_glyph_code = '0;
    logic [2:0]  i_glyph_line = '0;
    logic [7:0]  i_glyph_bits = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_pixels;
    logic [1:0]  o_cell_kind;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // mirror of the registers and the font store
    logic [7:0] disp_mode_q = '0;
    logic [7:0] scr_colors_q = '0;
    logic [7:0] txt_window_q = '0;
    logic [7:0] txt_colors_q = '0;
    logic [7:0] font_mirror [GLYPH_COUNT_DEF*GLYPH_LINES];
    bit         font_written [GLYPH_COUNT_DEF*GLYPH_LINES];
    logic [9:0] font_filled [$];

    t_row_res pending_rows [$];
    int       err_count = 0;
    int       cycle_cnt = 0;
    bit       calm = 1'b0;

    text_graphics_cell_row_renderer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_cell_col   (i_cell_col),
        .i_cell_row   (i_cell_row),
        .i_line       (i_line),
        .i_cell_byte  (i_cell_byte),
        .i_glyph_code (i_glyph_code),
        .i_glyph_line (i_glyph_line),
        .i_glyph_bits (i_glyph_bits),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixels     (o_pixels),
        .o_cell_kind  (o_cell_kind),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 i_clk = ~i_clk;

    // random idle decision shared by both channels
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 33);
    endfunction

    // expected row of a render item; also reports whether the font is read and where
    function automatic t_row_res predict_cell_row(input t_cell_item it,
                                                  output logic reads_font,
                                                  output logic [9:0] font_addr);
        t_row_res   r;
        logic [3:0] back;
        logic [3:0] fg;
        logic [3:0] bg;
        logic [3:0] c;
        logic [4:0] xmax;
        logic [3:0] ymax;
        logic       in_x;
        logic       in_y;
        logic [6:0] code;
        logic [7:0] pat;
        logic [2:0] bit_hi;
        t_gmode     gmode;
        back = scr_colors_q[3:0];
        fg = txt_colors_q[7:4];
        bg = txt_colors_q[3:0];
        gmode = t_gmode'(disp_mode_q[1:0]);
        r.pixels = {8{back}};
        r.kind = KIND_BG;
        reads_font = 1'b0;
        font_addr = '0;
        if (it.cell_row != 0 && it.cell_col >= COL_FIRST && it.cell_col < COL_END) begin
            xmax = {txt_window_q[3:0], 1'b0};
            ymax = txt_window_q[7:4];
            in_x = disp_mode_q[MODE_INV_X_BIT] ? (it.cell_col >= xmax) : (it.cell_col < xmax);
            in_y = disp_mode_q[MODE_INV_Y_BIT] ? (it.cell_row >= ymax) : (it.cell_row < ymax);
            if (in_x && in_y) begin
                // text cell, glyph blanked past the text columns
                code = (it.cell_col < TEXT_COL_END) ? it.cell_byte[6:0] : 7'd0;
                r.kind = KIND_TEXT;
                r.pixels = {8{bg}};
                if (code != 0 && it.line < 8) begin
                    reads_font = 1'b1;
                    font_addr = {code, it.line[2:0]};
                    pat = font_mirror[font_addr];
                    for (int i = 0; i < 8; i++) begin
                        r.pixels[31-4*i -: 4] = pat[7-i] ? fg : bg;
                    end
                end
            end else if (gmode == GMODE_BLOCK) begin
                // 2x4 blocks, two bits per band of four lines
                bit_hi = 3'd7 - {it.line[3:2], 1'b0};
                r.kind = KIND_BLOCK;
                r.pixels[31:16] = {4{it.cell_byte[bit_hi] ? scr_colors_q[7:4] : back}};
                r.pixels[15:0] = {4{it.cell_byte[bit_hi-1] ? scr_colors_q[7:4] : back}};
            end else if (gmode == GMODE_HALVES) begin
                c = (it.line < 8) ? it.cell_byte[7:4] : it.cell_byte[3:0];
                r.kind = KIND_HALVES;
                r.pixels = {8{(c != 0) ? c : back}};
            end
        end
        return r;
    endfunction

    function automatic t_step reg_step(input t_reg_idx idx, input logic [7:0] v);
        t_step s;
        s = '0;
        s.step = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = v;
        return s;
    endfunction

    function automatic t_step load_step(input logic [6:0] code, input logic [2:0] ln,
                                        input logic [7:0] bits);
        t_step s;
        s = '0;
        s.step = STEP_ITEM;
        s.item.cmd = CMD_LOAD;
        s.item.glyph_code = code;
        s.item.glyph_line = ln;
        s.item.glyph_bits = bits;
        return s;
    endfunction

    function automatic t_step render_step(input logic [4:0] col, input logic [3:0] row,
                                          input logic [3:0] ln, input logic [7:0] cbyte);
        t_step s;
        s = '0;
        s.step = STEP_ITEM;
        s.item.cmd = CMD_RENDER;
        s.item.cell_col = col;
        s.item.cell_row = row;
        s.item.line = ln;
        s.item.cell_byte = cbyte;
        return s;
    endfunction

    function automatic t_step typed_step(input logic [4:0] col, input logic [3:0] row,
                                         input logic [3:0] ln, input logic [7:0] cbyte,
                                         input logic [31:0] pix, input t_cell_kind kind);
        t_step s;
        s = render_step(col, row, ln, cbyte);
        s.typed = 1'b1;
        s.row.pixels = pix;
        s.row.kind = kind;
        return s;
    endfunction

    // drop valid and wait until every row is out and the pipe is empty
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_rows.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // setup phase and access phase on the register port, then the port goes idle
    task automatic write_reg(input t_reg_idx idx, input logic [7:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_DISPLAY_MODE:  disp_mode_q = v;
            REG_SCREEN_COLORS: scr_colors_q = v;
            REG_TEXT_WINDOW:   txt_window_q = v;
            REG_TEXT_COLORS:   txt_colors_q = v;
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one item, wait for it to be taken, then update the font mirror or queue the expected row
    task automatic send_cell_item(input t_cell_item it, input logic typed,
                                  input t_row_res typed_row);
        t_row_res   row;
        logic       rd;
        logic [9:0] fa;
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd <= it.cmd;
        i_cell_col <= it.cell_col;
        i_cell_row <= it.cell_row;
        i_line <= it.line;
        i_cell_byte <= it.cell_byte;
        i_glyph_code <= it.glyph_code;
        i_glyph_line <= it.glyph_line;
        i_glyph_bits <= it.glyph_bits;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.cmd == CMD_LOAD) begin
            fa = {it.glyph_code, it.glyph_line};
            font_mirror[fa] = it.glyph_bits;
            if (it.glyph_code != 0 && !font_written[fa]) begin
                font_filled.push_back(fa);
            end
            font_written[fa] = 1'b1;
        end else begin
            row = predict_cell_row(it, rd, fa);
            pending_rows.push_back(typed ? typed_row : row);
        end
    endtask

    // output side: random stall and row check
    always @(posedge i_clk) begin : out_side
        t_row_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_rows.size() == 0) begin
                $error("row with no render item pending: pixels %h kind %0d",
                       o_pixels, o_cell_kind);
                err_count++;
            end else begin
                want = pending_rows.pop_front();
                if (o_pixels !== want.pixels) begin
                    $error("pixels: expected %h, got %h", want.pixels, o_pixels);
                    err_count++;
                end
                if (o_cell_kind !== want.kind) begin
                    $error("cell_kind: expected %0d, got %0d", want.kind, o_cell_kind);
                    err_count++;
                end
            end
        end
        i_out_ready <= !take_break();
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        t_step      dir_steps [$];
        t_cell_item it;
        t_row_res   pr;
        logic       rd;
        logic [9:0] fa;
        logic [7:0] v;

        // reset
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: everything shows background colour 0
        dir_steps.push_back(typed_step(5'd0, 4'd0, 4'd0, 8'h00, 32'h0, KIND_BG));
        dir_steps.push_back(typed_step(5'd31, 4'd15, 4'd15, 8'hff, 32'h0, KIND_BG));
        dir_steps.push_back(typed_step(5'd2, 4'd1, 4'd0, 8'h7f, 32'h0, KIND_BG));
        // font bytes, three of them used by the text rows below
        dir_steps.push_back(load_step(7'h7f, 3'd0, 8'h81));
        dir_steps.push_back(load_step(7'h01, 3'd7, 8'hff));
        dir_steps.push_back(load_step(7'h55, 3'd3, 8'ha5));
        dir_steps.push_back(load_step(7'h2a, 3'd4, 8'h5a));
        dir_steps.push_back(load_step(7'h00, 3'd0, 8'h00));
        // block mode, widest window
        dir_steps.push_back(reg_step(REG_DISPLAY_MODE, 8'h01));
        dir_steps.push_back(reg_step(REG_SCREEN_COLORS, 8'ha5));
        dir_steps.push_back(reg_step(REG_TEXT_WINDOW, 8'hff));
        dir_steps.push_back(reg_step(REG_TEXT_COLORS, 8'hf0));
        dir_steps.push_back(typed_step(5'd2, 4'd1, 4'd0, 8'h7f, 32'hf000000f, KIND_TEXT));
        dir_steps.push_back(typed_step(5'd25, 4'd14, 4'd7, 8'h81, 32'hffffffff, KIND_TEXT));
        // column past the text columns, lower half of the cell, glyph zero
        dir_steps.push_back(typed_step(5'd26, 4'd1, 4'd0, 8'h7f, 32'h0, KIND_TEXT));
        dir_steps.push_back(typed_step(5'd3, 4'd2, 4'd8, 8'h7f, 32'h0, KIND_TEXT));
        dir_steps.push_back(typed_step(5'd4, 4'd3, 4'd0, 8'h80, 32'h0, KIND_TEXT));
        dir_steps.push_back(typed_step(5'd28, 4'd15, 4'd0, 8'h80, 32'haaaa5555, KIND_BLOCK));
        dir_steps.push_back(typed_step(5'd10, 4'd15, 4'd12, 8'h01, 32'h5555aaaa, KIND_BLOCK));
        dir_steps.push_back(render_step(5'd27, 4'd15, 4'd5, 8'h6c));
        // never drawn: row 0, left two and right three columns
        dir_steps.push_back(typed_step(5'd5, 4'd0, 4'd0, 8'hff, 32'h55555555, KIND_BG));
        dir_steps.push_back(typed_step(5'd1, 4'd4, 4'd0, 8'hff, 32'h55555555, KIND_BG));
        dir_steps.push_back(typed_step(5'd29, 4'd4, 4'd0, 8'hff, 32'h55555555, KIND_BG));
        // colour halves with both window axes inverted
        dir_steps.push_back(reg_step(REG_DISPLAY_MODE, 8'hc3));
        dir_steps.push_back(reg_step(REG_TEXT_WINDOW, 8'h88));
        dir_steps.push_back(typed_step(5'd2, 4'd1, 4'd0, 8'h3c, 32'h33333333, KIND_HALVES));
        dir_steps.push_back(typed_step(5'd5, 4'd9, 4'd15, 8'h30, 32'h55555555, KIND_HALVES));
        dir_steps.push_back(typed_step(5'd16, 4'd8, 4'd3, 8'h55, 32'hf0f00f0f, KIND_TEXT));
        // load right before a render of the same byte
        dir_steps.push_back(load_step(7'h2a, 3'd2, 8'h3c));
        dir_steps.push_back(typed_step(5'd20, 4'd9, 4'd2, 8'haa, 32'h00ffff00, KIND_TEXT));
        dir_steps.push_back(render_step(5'd15, 4'd7, 4'd9, 8'he7));
        // mode 2 shows background outside the window
        dir_steps.push_back(reg_step(REG_DISPLAY_MODE, 8'h02));
        dir_steps.push_back(reg_step(REG_TEXT_COLORS, 8'h3c));
        dir_steps.push_back(typed_step(5'd20, 4'd1, 4'd0, 8'hff, 32'h55555555, KIND_BG));
        dir_steps.push_back(render_step(5'd3, 4'd3, 4'd3, 8'hd5));

        foreach (dir_steps[k]) begin
            if (dir_steps[k].step == STEP_REG) begin
                wait_drained();
                write_reg(dir_steps[k].reg_idx, dir_steps[k].reg_val);
            end else begin
                send_cell_item(dir_steps[k].item, dir_steps[k].typed, dir_steps[k].row);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained();
            calm = (ph == 4 || ph == 5);
            for (int r = 0; r < 4; r++) begin
                v = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hff : 8'($urandom_range(255));
                write_reg(t_reg_idx'(r), v);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                it.cmd = ($urandom_range(99) < 25) ? CMD_LOAD : CMD_RENDER;
                it.cell_col = 5'($urandom_range(31));
                it.cell_row = 4'($urandom_range(15));
                it.line = 4'($urandom_range(15));
                it.cell_byte = 8'($urandom_range(255));
                it.glyph_code = 7'($urandom_range(127));
                it.glyph_line = 3'($urandom_range(7));
                it.glyph_bits = 8'($urandom_range(255));
                if (it.cmd == CMD_RENDER) begin
                    // steer font reads onto bytes that were loaded
                    pr = predict_cell_row(it, rd, fa);
                    if (rd && !font_written[fa]) begin
                        fa = font_filled[$urandom_range(font_filled.size() - 1)];
                        it.cell_byte[6:0] = fa[9:3];
                        it.line = {1'b0, fa[2:0]};
                    end
                end
                send_cell_item(it, 1'b0, '0);
            end
        end

        // drain and finish
        calm = 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pending_rows.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
